// ----- src/black_border_detector_defines.svh -----
// assertion macros for the black border detector
`ifndef BLACK_BORDER_DETECTOR_DEFINES_SVH
`define BLACK_BORDER_DETECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BBD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BBD_ASSERT(lbl, clk, rst, prop, msg)
`define BBD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- src/bbd_pkg.sv -----
// shared types, sizes and constants of the black border detector
package bbd_pkg;

   localparam int MAX_W = 4096;
   localparam int MAX_H = 4096;
   localparam int MAX_WH = (MAX_W > MAX_H) ? MAX_W : MAX_H;

   localparam int X_W = $clog2(MAX_W);
   localparam int Y_W = $clog2(MAX_H);
   localparam int SZ_W = $clog2(MAX_WH + 1);
   localparam int CFG_W = 13;
   localparam int THR_W = 8;
   localparam int PROD_W = THR_W + SZ_W;
   localparam int SUM_W = $clog2(MAX_WH * 255 + 1);

   localparam int PIX_W = 8;
   localparam int GRAY_W = 8;
   localparam int GRAY_ACC_W = 22;
   localparam int GRAY_SHIFT = 14;
   localparam logic [GRAY_ACC_W-1:0] GRAY_R = GRAY_ACC_W'(4899);
   localparam logic [GRAY_ACC_W-1:0] GRAY_G = GRAY_ACC_W'(9617);
   localparam logic [GRAY_ACC_W-1:0] GRAY_B = GRAY_ACC_W'(1868);
   localparam logic [GRAY_ACC_W-1:0] GRAY_RND = GRAY_ACC_W'(8192);

   localparam int OUT_POS_W = 12;
   localparam int OUT_SIZE_W = 13;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DARK_LEVEL = 2'd2;

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RST = 13'd640;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;
   localparam logic [THR_W-1:0] DARK_LEVEL_RST = 8'd16;

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int CRED_W = FIFO_CNT_W + 1;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } req_type;

   typedef struct packed {
      logic [OUT_POS_W-1:0]  crop_left;
      logic [OUT_POS_W-1:0]  crop_top;
      logic [OUT_SIZE_W-1:0] crop_width;
      logic [OUT_SIZE_W-1:0] crop_height;
      logic                  bars_found;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [X_W-1:0]    x;
      logic [Y_W-1:0]    y;
      logic              first_row;
      logic              row_end;
      logic              last_row;
      logic [GRAY_W-1:0] gray;
   } s1_type;

   typedef struct packed {
      logic             en;
      logic [X_W-1:0]   addr;
      logic [SUM_W-1:0] data;
   } ram_wr_type;

endpackage

// ----- src/bbd_col_ram.sv -----
// column sum memory, one write and one registered read port
module bbd_col_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 20
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- src/bbd_front.sv -----
// raster position tracking, request stage and gray conversion
`include "black_border_detector_defines.svh"

module bbd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  bbd_pkg::req_type          req_data,
   input  logic [bbd_pkg::SZ_W-1:0]  width_eff,
   input  logic [bbd_pkg::SZ_W-1:0]  height_eff,
   output bbd_pkg::s1_type           s1
);

   logic [bbd_pkg::X_W-1:0] x_ff, x_in;
   logic [bbd_pkg::Y_W-1:0] y_ff, y_in;
   logic                    row_end, last_row;

   logic                    valid_ff;
   logic [bbd_pkg::X_W-1:0] x1_ff;
   logic [bbd_pkg::Y_W-1:0] y1_ff;
   logic                    first_row_ff, row_end_ff, last_row_ff;
   bbd_pkg::req_type        pix_ff;

   logic [bbd_pkg::GRAY_ACC_W-1:0] acc;

   always_comb begin
      row_end = bbd_pkg::SZ_W'(x_ff) >= width_eff - bbd_pkg::SZ_W'(1);
      last_row = bbd_pkg::SZ_W'(y_ff) >= height_eff - bbd_pkg::SZ_W'(1);
      x_in = x_ff;
      y_in = y_ff;
      if (accept) begin
         if (row_end) begin
            x_in = '0;
            y_in = last_row ? '0 : y_ff + bbd_pkg::Y_W'(1);
         end else begin
            x_in = x_ff + bbd_pkg::X_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x1_ff <= x_ff;
         y1_ff <= y_ff;
         first_row_ff <= (y_ff == '0);
         row_end_ff <= row_end;
         last_row_ff <= last_row;
         pix_ff <= req_data;
      end
   end

   // bt.601 weights, 14 fractional bits, rounded
   always_comb begin
      acc = bbd_pkg::GRAY_ACC_W'(pix_ff.red) * bbd_pkg::GRAY_R
          + bbd_pkg::GRAY_ACC_W'(pix_ff.green) * bbd_pkg::GRAY_G
          + bbd_pkg::GRAY_ACC_W'(pix_ff.blue) * bbd_pkg::GRAY_B
          + bbd_pkg::GRAY_RND;
      s1.valid = valid_ff;
      s1.x = x1_ff;
      s1.y = y1_ff;
      s1.first_row = first_row_ff;
      s1.row_end = row_end_ff;
      s1.last_row = last_row_ff;
      s1.gray = acc[bbd_pkg::GRAY_SHIFT +: bbd_pkg::GRAY_W];
   end

   `BBD_ASSERT(a_frame_wrap, clock, reset, accept && row_end && last_row |=> x_ff == '0 && y_ff == '0, "position did not return to origin after frame end")

endmodule

// ----- src/bbd_accum.sv -----
// column and row sum update, content bounds and result formation
`include "black_border_detector_defines.svh"

module bbd_accum (
   input  logic                        clock,
   input  logic                        reset,
   input  bbd_pkg::s1_type             s1,
   input  logic [bbd_pkg::SUM_W-1:0]   rd_data,
   input  logic [bbd_pkg::PROD_W-1:0]  thr_width,
   input  logic [bbd_pkg::PROD_W-1:0]  thr_height,
   input  logic [bbd_pkg::SZ_W-1:0]    width_eff,
   input  logic [bbd_pkg::SZ_W-1:0]    height_eff,
   output bbd_pkg::ram_wr_type         ram_wr,
   output logic                        push,
   output bbd_pkg::rsp_type            push_data,
   output logic [1:0]                  pending
);

   bbd_pkg::s1_type s2_ff;

   logic                      fwd_valid_ff;
   logic [bbd_pkg::X_W-1:0]   fwd_addr_ff;
   logic [bbd_pkg::SUM_W-1:0] fwd_data_ff;

   logic [bbd_pkg::SUM_W-1:0] row_sum_ff, row_sum_in;
   logic                      row_seen_ff, row_seen_in;
   logic                      col_seen_ff, col_seen_in;
   logic [bbd_pkg::Y_W-1:0]   first_row_ff, first_row_in;
   logic [bbd_pkg::Y_W-1:0]   last_row_ff, last_row_in;
   logic [bbd_pkg::X_W-1:0]   first_col_ff, first_col_in;
   logic [bbd_pkg::X_W-1:0]   last_col_ff, last_col_in;

   logic                      s3_valid_ff;
   logic                      s3_found_ff;
   logic [bbd_pkg::Y_W-1:0]   s3_first_row_ff, s3_last_row_ff;
   logic [bbd_pkg::X_W-1:0]   s3_first_col_ff, s3_last_col_ff;

   logic [bbd_pkg::SUM_W-1:0] base, csum, rsum;
   logic                      col_hit, row_hit, frame_end;

   always_comb begin
      base = (fwd_valid_ff && fwd_addr_ff == s2_ff.x) ? fwd_data_ff : rd_data;
      csum = s2_ff.first_row ? bbd_pkg::SUM_W'(s2_ff.gray)
                             : base + bbd_pkg::SUM_W'(s2_ff.gray);
      rsum = row_sum_ff + bbd_pkg::SUM_W'(s2_ff.gray);
      col_hit = s2_ff.valid && s2_ff.last_row && (bbd_pkg::PROD_W'(csum) > thr_height);
      row_hit = s2_ff.valid && s2_ff.row_end && (bbd_pkg::PROD_W'(rsum) > thr_width);
      frame_end = s2_ff.valid && s2_ff.row_end && s2_ff.last_row;

      col_seen_in = col_seen_ff | col_hit;
      first_col_in = (col_hit && !col_seen_ff) ? s2_ff.x : first_col_ff;
      last_col_in = col_hit ? s2_ff.x : last_col_ff;
      row_seen_in = row_seen_ff | row_hit;
      first_row_in = (row_hit && !row_seen_ff) ? s2_ff.y : first_row_ff;
      last_row_in = row_hit ? s2_ff.y : last_row_ff;
      row_sum_in = row_sum_ff;
      if (s2_ff.valid) begin
         row_sum_in = s2_ff.row_end ? '0 : rsum;
      end

      ram_wr.en = s2_ff.valid;
      ram_wr.addr = s2_ff.x;
      ram_wr.data = csum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff <= '0;
         fwd_valid_ff <= 1'b0;
         row_sum_ff <= '0;
         row_seen_ff <= 1'b0;
         col_seen_ff <= 1'b0;
         first_row_ff <= '0;
         last_row_ff <= '0;
         first_col_ff <= '0;
         last_col_ff <= '0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_ff <= s1;
         fwd_valid_ff <= s2_ff.valid;
         s3_valid_ff <= frame_end;
         row_sum_ff <= row_sum_in;
         if (frame_end) begin
            row_seen_ff <= 1'b0;
            col_seen_ff <= 1'b0;
            first_row_ff <= '0;
            last_row_ff <= '0;
            first_col_ff <= '0;
            last_col_ff <= '0;
         end else begin
            row_seen_ff <= row_seen_in;
            col_seen_ff <= col_seen_in;
            first_row_ff <= first_row_in;
            last_row_ff <= last_row_in;
            first_col_ff <= first_col_in;
            last_col_ff <= last_col_in;
         end
      end
   end

   // previous write, not yet visible to the read issued in the same cycle
   always_ff @(posedge clock) begin
      fwd_addr_ff <= s2_ff.x;
      fwd_data_ff <= csum;
   end

   always_ff @(posedge clock) begin
      if (frame_end) begin
         s3_found_ff <= row_seen_in && col_seen_in;
         s3_first_row_ff <= first_row_in;
         s3_last_row_ff <= last_row_in;
         s3_first_col_ff <= first_col_in;
         s3_last_col_ff <= last_col_in;
      end
   end

   always_comb begin
      push = s3_valid_ff;
      pending = {1'b0, frame_end} + {1'b0, s3_valid_ff};
      if (s3_found_ff) begin
         push_data.crop_left = bbd_pkg::OUT_POS_W'(s3_first_col_ff);
         push_data.crop_top = bbd_pkg::OUT_POS_W'(s3_first_row_ff);
         push_data.crop_width = bbd_pkg::OUT_SIZE_W'(s3_last_col_ff)
                              - bbd_pkg::OUT_SIZE_W'(s3_first_col_ff)
                              + bbd_pkg::OUT_SIZE_W'(1);
         push_data.crop_height = bbd_pkg::OUT_SIZE_W'(s3_last_row_ff)
                               - bbd_pkg::OUT_SIZE_W'(s3_first_row_ff)
                               + bbd_pkg::OUT_SIZE_W'(1);
         push_data.bars_found = 1'b1;
      end else begin
         push_data.crop_left = '0;
         push_data.crop_top = '0;
         push_data.crop_width = bbd_pkg::OUT_SIZE_W'(width_eff);
         push_data.crop_height = bbd_pkg::OUT_SIZE_W'(height_eff);
         push_data.bars_found = 1'b0;
      end
   end

   `BBD_ASSERT(a_frame_clear, clock, reset, frame_end |=> !row_seen_ff && !col_seen_ff && row_sum_ff == '0, "frame state not cleared after frame end")

endmodule

// ----- src/bbd_rsp_fifo.sv -----
// result queue in front of the response channel
`include "black_border_detector_defines.svh"

module bbd_rsp_fifo (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  bbd_pkg::rsp_type                 push_data,
   input  logic                             pop,
   output logic                             out_valid,
   output bbd_pkg::rsp_type                 out_data,
   output logic [bbd_pkg::FIFO_CNT_W-1:0]   count
);

   bbd_pkg::rsp_type                store [bbd_pkg::FIFO_DEPTH];
   logic [bbd_pkg::FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [bbd_pkg::FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [bbd_pkg::FIFO_CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + bbd_pkg::FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + bbd_pkg::FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + bbd_pkg::FIFO_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - bbd_pkg::FIFO_CNT_W'(1);
      end
      out_valid = (count_ff != '0);
      out_data = store[rd_ptr_ff];
      count = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store[wr_ptr_ff] <= push_data;
      end
   end

   `BBD_ASSERT(a_no_overflow, clock, reset, push && !pop |-> count_ff < bbd_pkg::FIFO_CNT_W'(bbd_pkg::FIFO_DEPTH), "result queue overflow")
   `BBD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> count_ff == '0, "result queue not empty after reset")

endmodule

// ----- src/black_border_detector.sv -----
// Letterbox detector: takes one RGB pixel per clock unless stalled, in raster
// order and, one pipeline pass after the last pixel of a frame, returns the
// content rectangle (first/last row and column whose mean gray level exceeds
// the dark level). Sustained rate is one pixel per cycle while req_stall is
// low; each frame's result is registered and then queued. Column sums live in
// a MAX_W-entry memory read in the cycle after a pixel is taken and written
// back in the cycle after, forwarding the last write when a column repeats.
// Column decisions are made while the last row streams through, so no scan
// follows the frame. Up to eight results are queued at the output; req_stall
// rises only when that queue, counting frames still in flight, is full.
// Frame size and threshold may be written between pixels once the block is
// idle; entries of the column memory need no clearing, as row 0 overwrites them.
module black_border_detector (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  bbd_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output bbd_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bbd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bbd_pkg::CFG_W-1:0]       csr_data
);

   logic [bbd_pkg::CFG_W-1:0]  frame_width_ff, frame_height_ff;
   logic [bbd_pkg::THR_W-1:0]  dark_level_ff;
   logic [bbd_pkg::SZ_W-1:0]   width_eff, height_eff;
   logic [bbd_pkg::PROD_W-1:0] thr_width_ff, thr_height_ff;

   logic                            accept;
   bbd_pkg::s1_type                 s1;
   logic [bbd_pkg::SUM_W-1:0]       rd_data;
   bbd_pkg::ram_wr_type             ram_wr;
   logic                            push;
   bbd_pkg::rsp_type                push_data;
   logic [1:0]                      pending;
   logic [bbd_pkg::FIFO_CNT_W-1:0]  fifo_count;
   logic [bbd_pkg::CRED_W-1:0]      occupancy;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff <= bbd_pkg::FRAME_WIDTH_RST;
         frame_height_ff <= bbd_pkg::FRAME_HEIGHT_RST;
         dark_level_ff <= bbd_pkg::DARK_LEVEL_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bbd_pkg::CSR_FRAME_WIDTH: begin
               frame_width_ff <= csr_data;
            end
            bbd_pkg::CSR_FRAME_HEIGHT: begin
               frame_height_ff <= csr_data;
            end
            bbd_pkg::CSR_DARK_LEVEL: begin
               dark_level_ff <= csr_data[bbd_pkg::THR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // sizes saturated to 1..max
   always_comb begin
      if (frame_width_ff == '0) begin
         width_eff = bbd_pkg::SZ_W'(1);
      end else if (32'(frame_width_ff) > 32'(bbd_pkg::MAX_W)) begin
         width_eff = bbd_pkg::SZ_W'(bbd_pkg::MAX_W);
      end else begin
         width_eff = bbd_pkg::SZ_W'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         height_eff = bbd_pkg::SZ_W'(1);
      end else if (32'(frame_height_ff) > 32'(bbd_pkg::MAX_H)) begin
         height_eff = bbd_pkg::SZ_W'(bbd_pkg::MAX_H);
      end else begin
         height_eff = bbd_pkg::SZ_W'(frame_height_ff);
      end
   end

   always_ff @(posedge clock) begin
      thr_width_ff <= bbd_pkg::PROD_W'(dark_level_ff) * bbd_pkg::PROD_W'(width_eff);
      thr_height_ff <= bbd_pkg::PROD_W'(dark_level_ff) * bbd_pkg::PROD_W'(height_eff);
   end

   // frames in flight plus queued results must fit the queue
   always_comb begin
      occupancy = bbd_pkg::CRED_W'(fifo_count)
                + bbd_pkg::CRED_W'(s1.valid && s1.row_end && s1.last_row)
                + bbd_pkg::CRED_W'(pending);
      req_stall = occupancy >= bbd_pkg::CRED_W'(bbd_pkg::FIFO_DEPTH);
      accept = req_valid && !req_stall;
   end

   bbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .s1         (s1)
   );

   bbd_col_ram #(
      .DEPTH (bbd_pkg::MAX_W),
      .WIDTH (bbd_pkg::SUM_W)
   ) u_col_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (s1.valid),
      .rd_addr (s1.x),
      .rd_data (rd_data)
   );

   bbd_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .s1         (s1),
      .rd_data    (rd_data),
      .thr_width  (thr_width_ff),
      .thr_height (thr_height_ff),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .ram_wr     (ram_wr),
      .push       (push),
      .push_data  (push_data),
      .pending    (pending)
   );

   bbd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (rsp_valid && !rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .count     (fifo_count)
   );

endmodule
